// ----- rtl/sclc_pkg.sv -----
// sclc_pkg: phase codes, reply bytes, register indexes and status type
// for the serial code lock controller; no dependencies
package sclc_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_ENROL_WAIT1 = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ENROL_CODE1 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ENROL_WAIT2 = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ENROL_CODE2 = 4'd3;
    localparam logic [PHASE_W-1:0] PH_IDLE        = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CODE        = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CMD         = 4'd6;
    localparam logic [PHASE_W-1:0] PH_OPEN_CW     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_OPEN_ACW    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ALARM       = 4'd9;

    // link bytes
    localparam logic [7:0] BYTE_START    = 8'h01;
    localparam logic [7:0] BYTE_READY    = 8'h02;
    localparam logic [7:0] BYTE_REENROL  = 8'h03;
    localparam logic [7:0] BYTE_OPENED   = 8'h04;
    localparam logic [7:0] BYTE_DENIED   = 8'h05;
    localparam logic [7:0] BYTE_ENROLLED = 8'h06;
    localparam logic [7:0] BYTE_OPEN_CMD = 8'h2B;
    localparam logic [7:0] BYTE_MATCH    = 8'h01;
    localparam logic [7:0] BYTE_NOMATCH  = 8'h00;

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_CW   = 2'd1;
    localparam logic [1:0] MOTOR_ACW  = 2'd2;

    localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd0;
    localparam logic [1:0] REG_OPEN_TICKS    = 2'd1;
    localparam logic [1:0] REG_ALARM_TICKS   = 2'd2;

    localparam logic [3:0]  ATTEMPT_LIMIT_RST = 4'd3;
    localparam logic [15:0] OPEN_TICKS_RST    = 16'd5000;
    localparam logic [15:0] ALARM_TICKS_RST   = 16'd3000;
    localparam logic [3:0]  FAIL_MAX          = 4'd15;

    typedef struct packed {
        logic       enrol_mode;
        logic       alarm_on;
        logic       door_light;
        logic [1:0] motor_drive;
    } status_t;

    function automatic status_t phase_status(input logic [PHASE_W-1:0] ph);
        status_t s;
        s.motor_drive = (ph == PH_OPEN_CW)  ? MOTOR_CW :
                        (ph == PH_OPEN_ACW) ? MOTOR_ACW : MOTOR_STOP;
        s.door_light  = (ph == PH_OPEN_CW) || (ph == PH_OPEN_ACW);
        s.alarm_on    = (ph == PH_ALARM);
        s.enrol_mode  = (ph <= PH_ENROL_CODE2);
        return s;
    endfunction

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

// ----- rtl/serial_code_lock_controller_unit.sv -----
// serial_code_lock_controller_unit: top level of the serial code lock controller
// depends on sclc_pkg
//
// A request carries either a received link byte (s_tuser = 0) or one
// millisecond tick (s_tuser = 1). Requests pass through an input register,
// one step of the lock state machine and a result register. A request that
// yields one result (no reply or one reply byte) is taken every cycle while
// m_tready is high; one that yields two reply bytes (the enrolment verdict)
// holds the result register until both bytes are taken. Status fields in every
// result give the state after that request. Write configuration only while
// no request is in flight.
module serial_code_lock_controller_unit
    import sclc_pkg::*;
#(
    parameter int CODE_LENGTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [9:8] motor_drive, [10] door_light,
                                   // [11] alarm_on, [12] enrol_mode, [15:13] zero
    output logic        m_tuser,   // [0] tx_valid
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [IDX_W:0] CODE_LAST = (IDX_W+1)'(CODE_LENGTH);

    // configuration
    logic [3:0]  attempt_limit_reg;
    logic [15:0] open_ticks_reg;
    logic [15:0] alarm_ticks_reg;

    // lock state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [3:0]         fail_reg, fail_next;
    logic [15:0]        timer_reg, timer_next;
    logic [7:0]         entry_code_reg   [CODE_LENGTH];
    logic [7:0]         confirm_code_reg [CODE_LENGTH];
    logic [7:0]         stored_code_reg  [CODE_LENGTH];

    // input register
    logic       in_vld_reg;
    logic       in_tick_reg;
    logic [7:0] in_byte_reg;

    // result register
    logic       out_vld_reg;
    logic       out_two_reg;
    logic       out_sel_reg;
    logic       out_txv_reg;
    logic [7:0] out_b0_reg;
    logic [7:0] out_b1_reg;
    status_t    out_stat_reg;

    logic       out_free;
    logic       advance;

    // step results
    logic       entry_we, confirm_we, store_copy;
    logic [1:0] tx_cnt;
    logic [7:0] tx0, tx1;
    logic       idx_in_range, code_done;
    logic [IDX_W-1:0] idx_inc;
    logic       enrol_eq, cmd_eq;
    logic [3:0] fail_inc;
    logic [15:0] timer_dec;
    logic [7:0] confirm_merged [CODE_LENGTH];

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = !out_two_reg || out_sel_reg;
    assign m_tuser  = out_txv_reg;
    assign m_tdata  = {3'b000, out_stat_reg, out_sel_reg ? out_b1_reg : out_b0_reg};

    assign out_free = !out_vld_reg || (m_tready && m_tlast);
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    // code byte bookkeeping
    assign idx_in_range = ({1'b0, idx_reg} < CODE_LAST);
    assign code_done    = (({1'b0, idx_reg} + 1'b1) >= CODE_LAST);
    assign idx_inc      = code_done ? '0 : IDX_W'({1'b0, idx_reg} + 1'b1);

    always_comb
    begin
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            confirm_merged[i] = (IDX_W'(i) == idx_reg) ? in_byte_reg : confirm_code_reg[i];
        end
    end

    always_comb
    begin
        enrol_eq = 1'b1;
        cmd_eq   = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (entry_code_reg[i] != confirm_merged[i])
            begin
                enrol_eq = 1'b0;
            end
            if (stored_code_reg[i] != entry_code_reg[i])
            begin
                cmd_eq = 1'b0;
            end
        end
    end

    assign fail_inc  = (fail_reg < FAIL_MAX) ? fail_reg + 4'd1 : fail_reg;
    assign timer_dec = (timer_reg != 16'd0) ? timer_reg - 16'd1 : 16'd0;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        fail_next  = fail_reg;
        timer_next = timer_reg;
        entry_we   = 1'b0;
        confirm_we = 1'b0;
        store_copy = 1'b0;
        tx_cnt     = 2'd0;
        tx0        = 8'h00;
        tx1        = 8'h00;
        if (in_tick_reg)
        begin
            if (phase_reg == PH_OPEN_CW || phase_reg == PH_OPEN_ACW
                || phase_reg == PH_ALARM)
            begin
                timer_next = timer_dec;
                if (timer_dec == 16'd0)
                begin
                    if (phase_reg == PH_OPEN_CW)
                    begin
                        phase_next = PH_OPEN_ACW;
                        timer_next = at_least_one(open_ticks_reg);
                    end
                    else
                    begin
                        if (phase_reg == PH_ALARM)
                        begin
                            fail_next = 4'd0;
                        end
                        phase_next = PH_IDLE;
                    end
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_ENROL_WAIT1, PH_ENROL_WAIT2:
                begin
                    if (in_byte_reg == BYTE_START)
                    begin
                        tx_cnt     = 2'd1;
                        tx0        = BYTE_READY;
                        idx_next   = '0;
                        phase_next = (phase_reg == PH_ENROL_WAIT1) ? PH_ENROL_CODE1
                                                                   : PH_ENROL_CODE2;
                    end
                end
                PH_ENROL_CODE1:
                begin
                    entry_we = idx_in_range;
                    idx_next = idx_inc;
                    if (code_done)
                    begin
                        phase_next = PH_ENROL_WAIT2;
                    end
                end
                PH_ENROL_CODE2:
                begin
                    confirm_we = idx_in_range;
                    idx_next   = idx_inc;
                    if (code_done)
                    begin
                        tx_cnt = 2'd2;
                        tx0    = BYTE_START;
                        tx1    = enrol_eq ? BYTE_MATCH : BYTE_NOMATCH;
                        if (enrol_eq)
                        begin
                            store_copy = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_ENROL_WAIT1;
                        end
                    end
                end
                PH_IDLE:
                begin
                    if (in_byte_reg == BYTE_START)
                    begin
                        idx_next   = '0;
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    entry_we = idx_in_range;
                    idx_next = idx_inc;
                    if (code_done)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    phase_next = PH_IDLE;
                    if (in_byte_reg == BYTE_OPEN_CMD)
                    begin
                        tx_cnt = 2'd1;
                        if (cmd_eq)
                        begin
                            tx0        = BYTE_OPENED;
                            phase_next = PH_OPEN_CW;
                            timer_next = at_least_one(open_ticks_reg);
                        end
                        else
                        begin
                            tx0       = BYTE_DENIED;
                            fail_next = fail_inc;
                            if (fail_inc >= attempt_limit_reg)
                            begin
                                phase_next = PH_ALARM;
                                timer_next = at_least_one(alarm_ticks_reg);
                            end
                        end
                    end
                    else if (in_byte_reg == BYTE_REENROL)
                    begin
                        tx_cnt = 2'd1;
                        if (cmd_eq)
                        begin
                            tx0        = BYTE_ENROLLED;
                            idx_next   = '0;
                            phase_next = PH_ENROL_WAIT1;
                        end
                        else
                        begin
                            tx0 = BYTE_DENIED;
                        end
                    end
                end
                PH_OPEN_CW, PH_OPEN_ACW, PH_ALARM:
                begin
                    // busy: bytes dropped
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_limit_reg <= ATTEMPT_LIMIT_RST;
            open_ticks_reg    <= OPEN_TICKS_RST;
            alarm_ticks_reg   <= ALARM_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ATTEMPT_LIMIT: attempt_limit_reg <= cfg_data[3:0];
                REG_OPEN_TICKS:    open_ticks_reg    <= cfg_data;
                REG_ALARM_TICKS:   alarm_ticks_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_ENROL_WAIT1;
            idx_reg     <= '0;
            fail_reg    <= 4'd0;
            timer_reg   <= 16'd0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            out_two_reg <= 1'b0;
            out_sel_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                fail_reg    <= fail_next;
                timer_reg   <= timer_next;
                out_vld_reg <= 1'b1;
                out_two_reg <= (tx_cnt == 2'd2);
                out_sel_reg <= 1'b0;
            end
            else if (out_vld_reg && m_tready)
            begin
                // second reply byte follows the first
                if (m_tlast)
                begin
                    out_vld_reg <= 1'b0;
                end
                else
                begin
                    out_sel_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_tick_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_txv_reg  <= (tx_cnt != 2'd0);
            out_b0_reg   <= tx0;
            out_b1_reg   <= tx1;
            out_stat_reg <= phase_status(phase_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && entry_we)
        begin
            entry_code_reg[idx_reg] <= in_byte_reg;
        end
        if (advance && confirm_we)
        begin
            confirm_code_reg[idx_reg] <= in_byte_reg;
        end
        if (advance && store_copy)
        begin
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                stored_code_reg[i] <= entry_code_reg[i];
            end
        end
    end

endmodule

// ----- test/tb_serial_code_lock_controller_unit.sv -----
// tb_serial_code_lock_controller_unit: self-checking bench for the serial code lock controller
// drives enrolment, door, alarm and re-enrol sequences plus random traffic and checks every
// result against a cycle-free model of the lock; depends on sclc_pkg and the unit top level
module tb_serial_code_lock_controller_unit;
    import sclc_pkg::*;

    localparam int     CODE_LEN    = 4;
    localparam int     MAX_IDLE    = 17;
    localparam int     RANDOM_REQS = 1350;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [CODE_LEN*8-1:0] HOME_CODE = 32'h2B0301A5;
    localparam logic [CODE_LEN*8-1:0] ALT_CODE  = 32'h00000000;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] motor;
        logic       door;
        logic       alarm;
        logic       enrol;
    } lock_reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // lock model state
    logic [PHASE_W-1:0]    lk_phase;
    logic [2:0]            lk_idx;
    logic [CODE_LEN*8-1:0] entry_code;
    logic [CODE_LEN*8-1:0] confirm_code;
    logic [CODE_LEN*8-1:0] stored_code;
    logic [3:0]            fail_cnt;
    logic [15:0]           act_timer;
    logic [3:0]            limit_cfg;
    logic [15:0]           open_cfg;
    logic [15:0]           alarm_cfg;

    lock_reply_t reply_q[$];
    lock_reply_t want;

    int     src_idle_max;
    int     sink_idle_max;
    int     sink_hold;
    int     errors;
    int     n_requests;
    int     n_results;
    int     n_opens;
    int     n_alarms;
    int     n_enrols;
    longint cycles;

    serial_code_lock_controller_unit #(
        .CODE_LENGTH(CODE_LEN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cycle limit of %0d reached, %0d results outstanding",
                     CYCLE_LIMIT, reply_q.size());
            $display("tb_serial_code_lock_controller_unit: errors");
            $finish;
        end
    end

    function automatic int pick_gap(input int mx);
        if (mx == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, mx);
    endfunction

    function automatic int pick_idle_max();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return MAX_IDLE;
            default: return $urandom_range(1, MAX_IDLE);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        errors++;
        $display("mismatch on %s in result %0d: got 0x%0h, want 0x%0h",
                 what, n_results, got, exp_val);
    endtask

    // ---------------------------------------------------------------- lock model

    function automatic logic code_byte_done();
        if (int'(lk_idx) + 1 >= CODE_LEN)
        begin
            lk_idx = 3'd0;
            return 1'b1;
        end
        lk_idx = lk_idx + 3'd1;
        return 1'b0;
    endfunction

    function automatic void push_reply(input logic valid, input logic [7:0] b, input logic last);
        lock_reply_t r;
        r.tx_valid = valid;
        r.tx_byte  = valid ? b : 8'h00;
        r.last     = last;
        r.motor    = (lk_phase == PH_OPEN_CW)  ? MOTOR_CW :
                     (lk_phase == PH_OPEN_ACW) ? MOTOR_ACW : MOTOR_STOP;
        r.door     = (lk_phase == PH_OPEN_CW) || (lk_phase == PH_OPEN_ACW);
        r.alarm    = (lk_phase == PH_ALARM);
        r.enrol    = (lk_phase <= PH_ENROL_CODE2);
        reply_q.push_back(r);
    endfunction

    function automatic void predict_lock_step(input logic tick, input logic [7:0] b);
        logic [7:0] tx [2];
        int         n;
        logic       same;
        n = 0;
        if (tick)
        begin
            if (lk_phase == PH_OPEN_CW || lk_phase == PH_OPEN_ACW || lk_phase == PH_ALARM)
            begin
                if (act_timer != 16'd0)
                    act_timer--;
                if (act_timer == 16'd0)
                begin
                    if (lk_phase == PH_OPEN_CW)
                    begin
                        lk_phase  = PH_OPEN_ACW;
                        act_timer = (open_cfg == 16'd0) ? 16'd1 : open_cfg;
                    end
                    else
                    begin
                        if (lk_phase == PH_ALARM)
                            fail_cnt = 4'd0;
                        lk_phase = PH_IDLE;
                    end
                end
            end
        end
        else
        begin
            case (lk_phase)
                PH_ENROL_WAIT1, PH_ENROL_WAIT2:
                begin
                    if (b == BYTE_START)
                    begin
                        tx[n] = BYTE_READY;
                        n++;
                        lk_idx   = 3'd0;
                        lk_phase = (lk_phase == PH_ENROL_WAIT1) ? PH_ENROL_CODE1 : PH_ENROL_CODE2;
                    end
                end
                PH_ENROL_CODE1:
                begin
                    if (lk_idx < CODE_LEN)
                        entry_code[int'(lk_idx)*8 +: 8] = b;
                    if (code_byte_done())
                        lk_phase = PH_ENROL_WAIT2;
                end
                PH_ENROL_CODE2:
                begin
                    if (lk_idx < CODE_LEN)
                        confirm_code[int'(lk_idx)*8 +: 8] = b;
                    if (code_byte_done())
                    begin
                        same  = (entry_code == confirm_code);
                        tx[0] = BYTE_START;
                        tx[1] = same ? BYTE_MATCH : BYTE_NOMATCH;
                        n     = 2;
                        if (same)
                        begin
                            stored_code = entry_code;
                            lk_phase    = PH_IDLE;
                            n_enrols++;
                        end
                        else
                            lk_phase = PH_ENROL_WAIT1;
                    end
                end
                PH_IDLE:
                begin
                    if (b == BYTE_START)
                    begin
                        lk_idx   = 3'd0;
                        lk_phase = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    if (lk_idx < CODE_LEN)
                        entry_code[int'(lk_idx)*8 +: 8] = b;
                    if (code_byte_done())
                        lk_phase = PH_CMD;
                end
                PH_CMD:
                begin
                    same     = (stored_code == entry_code);
                    lk_phase = PH_IDLE;
                    if (b == BYTE_OPEN_CMD)
                    begin
                        if (same)
                        begin
                            tx[n] = BYTE_OPENED;
                            n++;
                            lk_phase  = PH_OPEN_CW;
                            act_timer = (open_cfg == 16'd0) ? 16'd1 : open_cfg;
                            n_opens++;
                        end
                        else
                        begin
                            tx[n] = BYTE_DENIED;
                            n++;
                            if (fail_cnt < FAIL_MAX)
                                fail_cnt++;
                            if (fail_cnt >= limit_cfg)
                            begin
                                lk_phase  = PH_ALARM;
                                act_timer = (alarm_cfg == 16'd0) ? 16'd1 : alarm_cfg;
                                n_alarms++;
                            end
                        end
                    end
                    else if (b == BYTE_REENROL)
                    begin
                        if (same)
                        begin
                            tx[n] = BYTE_ENROLLED;
                            n++;
                            lk_idx   = 3'd0;
                            lk_phase = PH_ENROL_WAIT1;
                        end
                        else
                        begin
                            tx[n] = BYTE_DENIED;
                            n++;
                        end
                    end
                end
                PH_OPEN_CW, PH_OPEN_ACW, PH_ALARM:
                    ;
                default:
                    lk_phase = PH_IDLE;
            endcase
        end
        if (n == 0)
            push_reply(1'b0, 8'h00, 1'b1);
        else
            for (int k = 0; k < n; k++)
                push_reply(1'b1, tx[k], k == n - 1);
    endfunction

    // ---------------------------------------------------------------- result side

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready = 1'b0;
                sink_hold--;
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            sink_hold = pick_gap(sink_idle_max);
            if (reply_q.size() == 0)
                report_mismatch("unrequested result", m_tdata, 16'h0);
            else
            begin
                want = reply_q.pop_front();
                if (m_tuser !== want.tx_valid)
                    report_mismatch("tx_valid", 16'(m_tuser), 16'(want.tx_valid));
                if (m_tdata[7:0] !== want.tx_byte)
                    report_mismatch("tx_byte", 16'(m_tdata[7:0]), 16'(want.tx_byte));
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", 16'(m_tlast), 16'(want.last));
                if (m_tdata[9:8] !== want.motor)
                    report_mismatch("motor_drive", 16'(m_tdata[9:8]), 16'(want.motor));
                if (m_tdata[10] !== want.door)
                    report_mismatch("door_light", 16'(m_tdata[10]), 16'(want.door));
                if (m_tdata[11] !== want.alarm)
                    report_mismatch("alarm_on", 16'(m_tdata[11]), 16'(want.alarm));
                if (m_tdata[12] !== want.enrol)
                    report_mismatch("enrol_mode", 16'(m_tdata[12]), 16'(want.enrol));
                if (m_tdata[15:13] !== 3'b000)
                    report_mismatch("tdata padding", 16'(m_tdata[15:13]), 16'h0);
            end
        end
    end

    // ---------------------------------------------------------------- request side

    task automatic send_req(input logic tick, input logic [7:0] b);
        int gap;
        gap = pick_gap(src_idle_max);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = tick;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_lock_step(tick, b);
        n_requests++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_tick();
        send_req(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_code(input logic [CODE_LEN*8-1:0] code);
        for (int i = 0; i < CODE_LEN; i++)
            send_req(1'b0, code[i*8 +: 8]);
    endtask

    task automatic send_login(input logic [CODE_LEN*8-1:0] code, input logic [7:0] cmd);
        send_req(1'b0, BYTE_START);
        send_code(code);
        send_req(1'b0, cmd);
    endtask

    task automatic send_enrol(input logic [CODE_LEN*8-1:0] first,
                              input logic [CODE_LEN*8-1:0] second);
        send_req(1'b0, BYTE_START);
        send_code(first);
        send_req(1'b0, BYTE_START);
        send_code(second);
    endtask

    // ticks until the door or alarm is done; stray bytes in between must be ignored
    task automatic run_out_action(input int byte_pct);
        while (lk_phase == PH_OPEN_CW || lk_phase == PH_OPEN_ACW || lk_phase == PH_ALARM)
        begin
            if ($urandom_range(0, 99) < byte_pct)
                send_req(1'b0, 8'($urandom_range(0, 255)));
            else
                send_tick();
        end
    endtask

    task automatic wait_drained();
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ATTEMPT_LIMIT: limit_cfg = value[3:0];
            REG_OPEN_TICKS:    open_cfg  = value;
            REG_ALARM_TICKS:   alarm_cfg = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [3:0] limit, input logic [15:0] open_t,
                            input logic [15:0] alarm_t);
        wait_drained();
        write_reg(REG_ATTEMPT_LIMIT, {12'h000, limit});
        write_reg(REG_OPEN_TICKS, open_t);
        write_reg(REG_ALARM_TICKS, alarm_t);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_enrolment();
        // noise in the first wait, then a mismatching pair, then a good pair
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'hFF);
        send_tick();
        send_req(1'b0, BYTE_START);
        send_code(32'h7F80FF00);
        send_req(1'b0, BYTE_READY);
        send_req(1'b0, BYTE_START);
        send_code(32'h7F80FF01);
        send_enrol(HOME_CODE, HOME_CODE);
    endtask

    task automatic test_door();
        wait_drained();
        write_reg(REG_OPEN_TICKS, 16'd2);
        write_reg(REG_ALARM_TICKS, 16'd3);
        send_req(1'b0, 8'h55);
        send_tick();
        send_login(HOME_CODE, BYTE_OPEN_CMD);
        send_req(1'b0, BYTE_START);
        send_tick();
        send_req(1'b0, BYTE_OPEN_CMD);
        run_out_action(20);
        send_login(HOME_CODE, 8'h00);
        send_login(HOME_CODE, 8'hFF);
        send_login(HOME_CODE ^ 32'h80000000, BYTE_REENROL);
    endtask

    task automatic test_alarm();
        // reset limit of three, then a raised limit, a lowered one, zero, the top value and one
        repeat (3) send_login(HOME_CODE ^ 32'h00000001, BYTE_OPEN_CMD);
        run_out_action(20);
        set_regs(4'd5, 16'd2, 16'd3);
        repeat (3) send_login(32'hFFFFFFFF, BYTE_OPEN_CMD);
        set_regs(4'd2, 16'd2, 16'd3);
        send_login(32'hFFFFFFFF, BYTE_OPEN_CMD);
        run_out_action(20);
        set_regs(4'd0, 16'd2, 16'd1);
        send_login(HOME_CODE ^ 32'h00FF0000, BYTE_OPEN_CMD);
        run_out_action(0);
        set_regs(4'd15, 16'd2, 16'd2);
        repeat (15) send_login(HOME_CODE ^ 32'h01000000, BYTE_OPEN_CMD);
        run_out_action(10);
        set_regs(4'd1, 16'd0, 16'd0);
        send_login(HOME_CODE, BYTE_OPEN_CMD);
        run_out_action(0);
        send_login(32'h00000000, BYTE_OPEN_CMD);
        run_out_action(0);
    endtask

    task automatic test_reenrol();
        set_regs(4'd3, 16'd3, 16'd3);
        send_login(HOME_CODE, BYTE_REENROL);
        send_enrol(ALT_CODE, ALT_CODE);
        send_login(HOME_CODE, BYTE_OPEN_CMD);
        send_login(ALT_CODE, BYTE_OPEN_CMD);
        run_out_action(0);
    endtask

    task automatic test_long_actions();
        int src_keep;
        int sink_keep;
        src_keep      = src_idle_max;
        sink_keep     = sink_idle_max;
        src_idle_max  = 0;
        sink_idle_max = 0;
        set_regs(4'd1, 16'd40, 16'd60);
        send_login(ALT_CODE, BYTE_OPEN_CMD);
        run_out_action(0);
        send_login(HOME_CODE, BYTE_OPEN_CMD);
        run_out_action(0);
        src_idle_max  = src_keep;
        sink_idle_max = sink_keep;
    endtask

    task automatic test_random();
        logic [CODE_LEN*8-1:0] pending;
        logic [CODE_LEN*8-1:0] guess;
        logic [7:0]            cmd;
        int                    start;
        int                    next_cfg;
        int                    r;
        start    = n_requests;
        next_cfg = n_requests;
        pending  = (CODE_LEN*8)'({$urandom, $urandom});
        while (n_requests - start < RANDOM_REQS)
        begin
            if (n_requests >= next_cfg)
            begin
                next_cfg      = n_requests + 200;
                src_idle_max  = pick_idle_max();
                sink_idle_max = pick_idle_max();
                r = $urandom_range(0, 3);
                set_regs((r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom_range(1, 6)),
                         16'($urandom_range(0, 25)), 16'($urandom_range(0, 25)));
            end
            r = $urandom_range(0, 99);
            case (lk_phase)
                PH_ENROL_WAIT1, PH_ENROL_WAIT2:
                begin
                    if (r < 85)
                    begin
                        if (lk_phase == PH_ENROL_WAIT1)
                            pending = (CODE_LEN*8)'({$urandom, $urandom});
                        guess = ($urandom_range(0, 3) != 0) ? pending : 32'($urandom);
                        send_req(1'b0, BYTE_START);
                        send_code(lk_phase == PH_ENROL_CODE1 ? pending : guess);
                    end
                    else if (r < 93)
                        send_req(1'b0, 8'($urandom_range(0, 255)));
                    else
                        send_tick();
                end
                PH_OPEN_CW, PH_OPEN_ACW, PH_ALARM:
                begin
                    if (r < 85)
                        send_tick();
                    else
                        send_req(1'b0, 8'($urandom_range(0, 255)));
                end
                PH_IDLE:
                begin
                    if (r < 80)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 60)
                            guess = stored_code;
                        else if (r < 80)
                            guess = 32'($urandom);
                        else
                        begin
                            guess = stored_code;
                            guess[$urandom_range(0, CODE_LEN - 1)*8 +: 8] ^=
                                8'($urandom_range(1, 255));
                        end
                        r = $urandom_range(0, 99);
                        cmd = (r < 55) ? BYTE_OPEN_CMD :
                              (r < 75) ? BYTE_REENROL : 8'($urandom_range(0, 255));
                        send_login(guess, cmd);
                    end
                    else if (r < 90)
                        send_req(1'b0, 8'($urandom_range(0, 255)));
                    else
                        send_tick();
                end
                default:
                begin
                    // part-way through a code after a stray start byte
                    if (r < 85)
                        send_req(1'b0, 8'($urandom_range(0, 255)));
                    else
                        send_tick();
                end
            endcase
        end
    endtask

    initial
    begin
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ATTEMPT_LIMIT;
        cfg_data      = 16'h0000;
        rst_n         = 1'b0;
        src_idle_max  = MAX_IDLE;
        sink_idle_max = MAX_IDLE;
        sink_hold     = 0;
        errors        = 0;
        n_requests    = 0;
        n_results     = 0;
        n_opens       = 0;
        n_alarms      = 0;
        n_enrols      = 0;
        cycles        = 0;
        lk_phase      = PH_ENROL_WAIT1;
        lk_idx        = 3'd0;
        entry_code    = '0;
        confirm_code  = '0;
        stored_code   = '0;
        fail_cnt      = 4'd0;
        act_timer     = 16'd0;
        limit_cfg     = ATTEMPT_LIMIT_RST;
        open_cfg      = OPEN_TICKS_RST;
        alarm_cfg     = ALARM_TICKS_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_enrolment();
        test_door();
        test_alarm();
        test_reenrol();
        test_long_actions();
        test_random();
        wait_drained();
        repeat (10) @(posedge clk);

        $display("%0d requests, %0d results: %0d enrolments, %0d door cycles, %0d alarms",
                 n_requests, n_results, n_enrols, n_opens, n_alarms);
        $display("covered busy and idle ticks, stray bytes, limit changes, zero and long times");
        if (errors == 0)
            $display("tb_serial_code_lock_controller_unit: clean");
        else
            $display("tb_serial_code_lock_controller_unit: errors");
        $finish;
    end

endmodule
